>>> rtl/bchd_pkg.sv
// ----------------------------------------------------------------------------
// bchd_pkg
// Types and constants for the button click / hold detector.
// ----------------------------------------------------------------------------
package bchd_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgIdxW = 2;

  typedef logic [TimeW-1:0] time_ms_t;

  // action code reported per sample
  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_CLICKED = 2'd1,
    ACT_HELD    = 2'd2
  } action_e;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_ACTIVE_LOW = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_TIME  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE   = 2'd2;

  // register reset values
  localparam time_ms_t HoldTimeRst = 32'd1000;
  localparam time_ms_t DebounceRst = 32'd20;

  // input and output beat widths
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 8;

endpackage

>>> rtl/button_click_hold_detector.sv
// ----------------------------------------------------------------------------
// button_click_hold_detector
// Debounced click and long-press detection on timestamped pin samples.
// ----------------------------------------------------------------------------
//  channel   | direction | beat contents
//  s_axis    | in        | tdata[0] pin_level, tdata[32:1] now_ms, rest zero
//  m_axis    | out       | tdata[1:0] action, rest zero
//  cfg       | in        | we/idx/data: 0 active_low, 1 hold_time, 2 debounce
//
//  One beat in, one beat out; a new sample is taken every cycle unless m_axis
//  stalls. Each sample passes an input register, then one pass of two 32-bit
//  subtract and compare paths into the result register, which also updates
//  the state. A stall on m_axis holds the result register and backs up
//  through the input register to s_axis_tready. Reset clears the state and
//  loads the register defaults (active high, 1000 ms hold, 20 ms debounce).
// ----------------------------------------------------------------------------
module button_click_hold_detector
  import bchd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // sample stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [0] pin_level, [32:1] now_ms
  // action stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [1:0] action
  // configuration
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [TimeW-1:0]    cfg_data_i
);

  // configuration registers
  logic     active_low_q;
  time_ms_t hold_time_q;
  time_ms_t debounce_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_low_q <= 1'b0;
      hold_time_q  <= HoldTimeRst;
      debounce_q   <= DebounceRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ACTIVE_LOW: active_low_q <= cfg_data_i[0];
        CFG_HOLD_TIME:  hold_time_q  <= cfg_data_i;
        CFG_DEBOUNCE:   debounce_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic     s1_valid_q;
  logic     s1_level_q;
  time_ms_t s1_now_q;
  logic     out_valid_q;
  action_e  out_action_q;
  logic     advance;
  logic     in_fire;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_level_q <= s_axis_tdata[0];
      s1_now_q   <= s_axis_tdata[TimeW:1];
    end
  end

  // detector state
  logic     prev_pressed_q, prev_pressed_d;
  time_ms_t press_time_q, press_time_d;
  time_ms_t release_time_q, release_time_d;
  logic     ignore_release_q, ignore_release_d;
  action_e  action_d;
  logic     step;

  logic     pressed;
  logic     settled;
  logic     press_edge;
  logic     release_edge;
  logic     hold_hit;
  time_ms_t since_release;
  time_ms_t since_press;

  assign step          = s1_valid_q && advance;
  assign pressed       = s1_level_q ^ active_low_q;
  assign since_release = s1_now_q - release_time_q;
  assign since_press   = s1_now_q - press_time_q;
  assign settled       = since_release > debounce_q;
  assign press_edge    = pressed && !prev_pressed_q && settled;
  assign release_edge  = !pressed && prev_pressed_q && settled;
  // no hold is reported on the step that records a new press
  assign hold_hit      = pressed && !press_edge && (since_press > hold_time_q);

  always_comb begin
    prev_pressed_d   = pressed;
    press_time_d     = press_time_q;
    release_time_d   = release_time_q;
    ignore_release_d = ignore_release_q;
    action_d         = ACT_NONE;
    if (press_edge) begin
      press_time_d = s1_now_q;
    end
    if (release_edge) begin
      release_time_d = s1_now_q;
      if (!ignore_release_q) begin
        action_d = ACT_CLICKED;
      end else begin
        ignore_release_d = 1'b0;
      end
    end
    if (hold_hit) begin
      // report and restart the hold timer
      action_d         = ACT_HELD;
      ignore_release_d = 1'b1;
      press_time_d     = s1_now_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_pressed_q   <= 1'b0;
      press_time_q     <= '0;
      release_time_q   <= '0;
      ignore_release_q <= 1'b0;
    end else if (step) begin
      prev_pressed_q   <= prev_pressed_d;
      press_time_q     <= press_time_d;
      release_time_q   <= release_time_d;
      ignore_release_q <= ignore_release_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_action_q <= action_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-2){1'b0}}, out_action_q};

  // checks
  a_no_bad_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_action_q == ACT_NONE || out_action_q == ACT_CLICKED ||
                     out_action_q == ACT_HELD))
    else $error("reserved action code on output");

  a_held_sets_ignore: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && hold_hit) |=> (ignore_release_q && out_action_q == ACT_HELD))
    else $error("held report did not arm release swallow");

  a_click_needs_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && action_d == ACT_CLICKED) |-> (prev_pressed_q && !ignore_release_q))
    else $error("click without a pressed-to-released edge");

  a_out_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result appeared without a staged sample");

endmodule
